FILE: rtl/crcft_pkg.sv
package crcft_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDR = 1'b1;

    localparam logic [7:0] CRC_POLY_RESET    = 8'h07;
    localparam logic [6:0] DEVICE_ADDR_RESET = 7'h08;

    localparam logic FUNC_RX = 1'b0;
    localparam logic FUNC_TX = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       start_flag;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       crc_ok;
        logic       is_crc;
        logic       last;
    } t_out_item;

    // MSB-first CRC-8 over one byte, x^8 term implied
    function automatic logic [7:0] crc8_byte(input logic [7:0] seed,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        logic       fb;
        c = seed;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/crcft_if.sv
interface crcft_in_if;
    logic                valid;
    logic                ready;
    crcft_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface crcft_out_if;
    logic                 valid;
    logic                 ready;
    crcft_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/crc8_framed_register_transfer_unit.sv
// CRC-8 byte framing for register transfers: in receive mode data/CRC byte pairs are
// checked and each pair yields one beat (data byte plus pass flag); in transmit mode a
// start item is echoed as one beat and each data byte yields two beats, the byte and
// its CRC. The first CRC of a transfer also covers the bus address prefix captured at
// the start item. One input beat is taken per cycle while the queue has room; the first
// result beat is registered and appears in the cycle after acceptance. The output port
// moves one beat per cycle while o_out.ready is high, and the two-entry output queue
// takes a new transmit data item only once it is empty or its one entry is leaving. CRCs
// of the read and write address bytes are kept precomputed from the current polynomial
// and address, so each item passes through one single-byte CRC stage.
module crc8_framed_register_transfer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crcft_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    crcft_in_if.sink                       i_in,
    crcft_out_if.source                    o_out
);
    import crcft_pkg::*;

    logic [7:0] r_poly,      n_poly;
    logic [6:0] r_addr,      n_addr;
    logic [7:0] r_wr_crc;
    logic [7:0] r_rd_crc;

    logic       r_expect_crc, n_expect_crc;
    logic       r_first_pair, n_first_pair;
    logic [7:0] r_held_data,  n_held_data;
    logic [7:0] r_seed_crc,   n_seed_crc;

    t_out_item  r_q0, n_q0;
    t_out_item  r_q1, n_q1;
    logic [1:0] r_cnt, n_cnt;

    logic       accept;
    logic       pop;
    logic [1:0] cnt_pop;
    t_out_item  q0_pop;
    t_out_item  res0, res1;
    logic [1:0] nres;
    logic [7:0] crc_seed, crc_data, crc_val;
    logic [7:0] base_crc;

    // Configuration
    always_comb begin
        n_poly = r_poly;
        n_addr = r_addr;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CRC_POLY:    n_poly = i_cfg_data;
                CFG_DEVICE_ADDR: n_addr = i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Output queue handshake
    assign pop         = (r_cnt != 2'd0) && o_out.ready;
    assign i_in.ready  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.payload = r_q0;

    // One shared CRC stage
    assign base_crc = r_first_pair ? r_seed_crc : 8'h00;
    assign crc_seed = (i_in.payload.func == FUNC_TX && i_in.payload.start_flag)
                      ? r_wr_crc : base_crc;
    assign crc_data = (i_in.payload.func == FUNC_TX) ? i_in.payload.data_byte : r_held_data;
    assign crc_val  = crc8_byte(crc_seed, crc_data, r_poly);

    always_comb begin
        n_expect_crc = r_expect_crc;
        n_first_pair = r_first_pair;
        n_held_data  = r_held_data;
        n_seed_crc   = r_seed_crc;
        res0         = '{out_byte: i_in.payload.data_byte, crc_ok: 1'b1,
                         is_crc: 1'b0, last: 1'b1};
        res1         = '{out_byte: crc_val, crc_ok: 1'b1, is_crc: 1'b1, last: 1'b1};
        nres         = 2'd0;
        if (accept) begin
            if (i_in.payload.func == FUNC_RX) begin
                if (i_in.payload.start_flag) begin
                    n_seed_crc   = r_rd_crc;
                    n_first_pair = 1'b1;
                    n_held_data  = i_in.payload.data_byte;
                    n_expect_crc = 1'b1;
                end else if (!r_expect_crc) begin
                    n_held_data  = i_in.payload.data_byte;
                    n_expect_crc = 1'b1;
                end else begin
                    res0 = '{out_byte: r_held_data,
                             crc_ok: (crc_val == i_in.payload.data_byte),
                             is_crc: 1'b0, last: 1'b1};
                    nres         = 2'd1;
                    n_first_pair = 1'b0;
                    n_expect_crc = 1'b0;
                end
            end else begin
                n_expect_crc = 1'b0;
                if (i_in.payload.start_flag) begin
                    n_seed_crc   = crc_val;
                    n_first_pair = 1'b1;
                    nres         = 2'd1;
                end else begin
                    res0.last    = 1'b0;
                    nres         = 2'd2;
                    n_first_pair = 1'b0;
                end
            end
        end
    end

    // Queue update: drain head first, then append this item's beats
    always_comb begin
        cnt_pop = r_cnt - {1'b0, pop};
        q0_pop  = pop ? r_q1 : r_q0;
        n_q0    = q0_pop;
        n_q1    = r_q1;
        if (nres != 2'd0) begin
            if (cnt_pop == 2'd0) begin
                n_q0 = res0;
            end else begin
                n_q1 = res0;
            end
        end
        if (nres == 2'd2) begin
            n_q1 = res1;
        end
        n_cnt = cnt_pop + nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly       <= CRC_POLY_RESET;
            r_addr       <= DEVICE_ADDR_RESET;
            r_wr_crc     <= crc8_byte(8'h00, {DEVICE_ADDR_RESET, 1'b0}, CRC_POLY_RESET);
            r_rd_crc     <= crc8_byte(8'h00, {DEVICE_ADDR_RESET, 1'b1}, CRC_POLY_RESET);
            r_expect_crc <= 1'b0;
            r_first_pair <= 1'b1;
            r_held_data  <= 8'h00;
            r_seed_crc   <= 8'h00;
            r_cnt        <= 2'd0;
        end else begin
            r_poly       <= n_poly;
            r_addr       <= n_addr;
            r_wr_crc     <= crc8_byte(8'h00, {n_addr, 1'b0}, n_poly);
            r_rd_crc     <= crc8_byte(8'h00, {n_addr, 1'b1}, n_poly);
            r_expect_crc <= n_expect_crc;
            r_first_pair <= n_first_pair;
            r_held_data  <= n_held_data;
            r_seed_crc   <= n_seed_crc;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue overfilled");

    a_tx_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.payload.func == FUNC_TX && !i_in.payload.start_flag)
        |=> (r_cnt == 2'd2) && !r_q0.is_crc && !r_q0.last && r_q1.is_crc && r_q1.last)
        else $error("transmit data beat not followed by its CRC beat");

    a_rx_check_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.payload.func == FUNC_RX && !i_in.payload.start_flag
         && r_expect_crc) |=> !r_expect_crc && !r_first_pair)
        else $error("receive pair did not close");

    a_crc_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.is_crc) |-> o_out.payload.last)
        else $error("CRC beat not marked last");

endmodule

FILE: test/crcft_frame_checker.sv
module crcft_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [crcft_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                      i_cfg_data,
    crcft_in_if                             in_ch,
    crcft_out_if                            out_ch,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import crcft_pkg::*;

    logic [7:0] crc_poly_q;
    logic [6:0] device_addr_q;
    logic       awaiting_crc;
    logic       first_pair;
    logic [7:0] held_byte;
    logic [7:0] prefix_crc;
    int         error_count = 0;
    t_out_item  expected_beats[$];

    // one byte through the CRC register, MSB first, top bit of the poly implied
    function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ b[k];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ crc_poly_q;
            end
        end
        return c;
    endfunction

    task automatic predict_frame_beats(input t_in_item it);
        logic [7:0] wr_addr;
        logic [7:0] rd_addr;
        logic [7:0] calc;
        wr_addr = {device_addr_q, 1'b0};
        rd_addr = {device_addr_q, 1'b1};
        if (it.func == FUNC_RX) begin
            if (it.start_flag) begin
                prefix_crc   = crc_fold(8'h00, rd_addr);
                first_pair   = 1'b1;
                held_byte    = it.data_byte;
                awaiting_crc = 1'b1;
            end else if (!awaiting_crc) begin
                held_byte    = it.data_byte;
                awaiting_crc = 1'b1;
            end else begin
                calc = crc_fold(first_pair ? prefix_crc : 8'h00, held_byte);
                expected_beats.push_back('{out_byte: held_byte,
                                           crc_ok: (calc == it.data_byte),
                                           is_crc: 1'b0, last: 1'b1});
                first_pair   = 1'b0;
                awaiting_crc = 1'b0;
            end
        end else begin
            // transmit drops any half-received pair
            awaiting_crc = 1'b0;
            if (it.start_flag) begin
                prefix_crc = crc_fold(crc_fold(8'h00, wr_addr), it.data_byte);
                first_pair = 1'b1;
                expected_beats.push_back('{out_byte: it.data_byte, crc_ok: 1'b1,
                                           is_crc: 1'b0, last: 1'b1});
            end else begin
                calc = crc_fold(first_pair ? prefix_crc : 8'h00, it.data_byte);
                expected_beats.push_back('{out_byte: it.data_byte, crc_ok: 1'b1,
                                           is_crc: 1'b0, last: 1'b0});
                expected_beats.push_back('{out_byte: calc, crc_ok: 1'b1,
                                           is_crc: 1'b1, last: 1'b1});
                first_pair = 1'b0;
            end
        end
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (expected_beats.size() == 0) begin
            $error("beat with nothing expected: out_byte %h crc_ok %b is_crc %b last %b",
                   got.out_byte, got.crc_ok, got.is_crc, got.last);
            error_count++;
        end else begin
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                error_count++;
            end
            if (got.crc_ok !== want.crc_ok) begin
                $error("crc_ok: expected %b, got %b", want.crc_ok, got.crc_ok);
                error_count++;
            end
            if (got.is_crc !== want.is_crc) begin
                $error("is_crc: expected %b, got %b", want.is_crc, got.is_crc);
                error_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                error_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crc_poly_q    = CRC_POLY_RESET;
            device_addr_q = DEVICE_ADDR_RESET;
            awaiting_crc  = 1'b0;
            first_pair    = 1'b1;
            held_byte     = 8'h00;
            prefix_crc    = 8'h00;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRC_POLY:    crc_poly_q = i_cfg_data;
                    CFG_DEVICE_ADDR: device_addr_q = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_frame_beats(in_ch.payload);
            end
            if (out_ch.valid && out_ch.ready) begin
                check_beat(out_ch.payload);
            end
        end
        o_pending <= expected_beats.size();
        o_errors  <= error_count;
    end

endmodule

FILE: test/tb_crc8_framed_register_transfer_unit.sv
module tb_crc8_framed_register_transfer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import crcft_pkg::*;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef enum int {RDY_OPEN, RDY_COIN, RDY_PATTERN, RDY_SPARSE} t_ready_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [7:0]           cfg_data;
    int                   errors;
    int                   pending;
    int                   cycles = 0;
    int                   burst_left = 0;
    int                   items_in_phase = 0;
    logic [7:0]           cur_poly;
    logic [6:0]           cur_dev;

    crcft_in_if  in_bus();
    crcft_out_if out_bus();

    crc8_framed_register_transfer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    crcft_frame_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_ch      (in_bus),
        .out_ch     (out_bus),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_crc8_framed_register_transfer_unit: done, errors");
            $finish;
        end
    end

    // one beat into the block; bursts of random length separated by random gaps
    task automatic put_byte(input logic fn, input logic [7:0] b, input logic start);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid   <= 1'b1;
        in_bus.payload <= '{func: fn, data_byte: b, start_flag: start};
        do @(posedge i_clk); while (!in_bus.ready);
        items_in_phase++;
    endtask

    // receive-only items leave no beat behind, so give the block a few more cycles
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] poly, input logic [6:0] dev);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_CRC_POLY;
        cfg_data <= poly;
        @(posedge i_clk);
        cfg_idx  <= CFG_DEVICE_ADDR;
        cfg_data <= {1'b0, dev};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_poly = poly;
        cur_dev  = dev;
    endtask

    // mostly the right CRC, now and then a corrupted one
    function automatic logic [7:0] crc_guess(input logic [7:0] good);
        logic [7:0] flip;
        flip = 8'($urandom_range(1, 255));
        return ($urandom_range(0, 9) < 8) ? good : (good ^ flip);
    endfunction

    task automatic run_directed();
        logic [7:0] seed;
        // no start since reset: the first pair covers its data byte alone
        put_byte(FUNC_RX, 8'h5A, 1'b0);
        put_byte(FUNC_RX, crc8_byte(8'h00, 8'h5A, cur_poly), 1'b0);
        put_byte(FUNC_TX, 8'hFF, 1'b0);
        seed = crc8_byte(8'h00, {cur_dev, 1'b1}, cur_poly);
        put_byte(FUNC_RX, 8'h00, 1'b1);
        put_byte(FUNC_RX, crc8_byte(seed, 8'h00, cur_poly), 1'b0);
        put_byte(FUNC_RX, 8'hFF, 1'b0);
        put_byte(FUNC_RX, crc8_byte(8'h00, 8'hFF, cur_poly) ^ 8'h01, 1'b0);
        put_byte(FUNC_RX, 8'h80, 1'b0);
        put_byte(FUNC_RX, crc8_byte(8'h00, 8'h80, cur_poly), 1'b0);
        put_byte(FUNC_TX, 8'hFF, 1'b1);
        put_byte(FUNC_TX, 8'h00, 1'b0);
        put_byte(FUNC_TX, 8'hFF, 1'b0);
        put_byte(FUNC_TX, 8'h01, 1'b0);
        // switch to transmit while a received byte is held
        put_byte(FUNC_RX, 8'h3C, 1'b1);
        put_byte(FUNC_TX, 8'hA5, 1'b0);
        put_byte(FUNC_RX, 8'h77, 1'b0);
        put_byte(FUNC_RX, 8'h00, 1'b0);
        // prefix from a transmit start feeds the next receive pair
        put_byte(FUNC_TX, 8'h00, 1'b1);
        seed = crc8_byte(crc8_byte(8'h00, {cur_dev, 1'b0}, cur_poly), 8'h00, cur_poly);
        put_byte(FUNC_RX, 8'h12, 1'b0);
        put_byte(FUNC_RX, crc8_byte(seed, 8'h12, cur_poly), 1'b0);
        // restart while a CRC byte is due
        put_byte(FUNC_RX, 8'hFF, 1'b1);
        put_byte(FUNC_RX, 8'h01, 1'b1);
        put_byte(FUNC_RX, 8'hFF, 1'b0);
    endtask

    task automatic run_random_phase();
        int         kind;
        int         pairs;
        logic [7:0] d;
        logic [7:0] seed;
        items_in_phase = 0;
        while (items_in_phase < ITEMS_PER_PHASE) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                pairs = $urandom_range(0, 5);
                seed  = crc8_byte(8'h00, {cur_dev, 1'b1}, cur_poly);
                d     = 8'($urandom_range(0, 255));
                put_byte(FUNC_RX, d, 1'b1);
                put_byte(FUNC_RX, crc_guess(crc8_byte(seed, d, cur_poly)), 1'b0);
                repeat (pairs) begin
                    d = 8'($urandom_range(0, 255));
                    put_byte(FUNC_RX, d, 1'b0);
                    put_byte(FUNC_RX, crc_guess(crc8_byte(8'h00, d, cur_poly)), 1'b0);
                end
            end else if (kind < 8) begin
                put_byte(FUNC_TX, 8'($urandom_range(0, 255)), 1'b1);
                repeat ($urandom_range(0, 6)) begin
                    put_byte(FUNC_TX, 8'($urandom_range(0, 255)), 1'b0);
                end
            end else begin
                // stray and broken sequences
                repeat ($urandom_range(1, 4)) begin
                    put_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             ($urandom_range(0, 3) == 0));
                end
            end
        end
    endtask

    initial begin
        logic [7:0] phase_poly [NUM_PHASES];
        logic [6:0] phase_dev  [NUM_PHASES];
        phase_poly[0] = 8'h00;               phase_dev[0] = 7'h7F;
        phase_poly[1] = 8'hFF;               phase_dev[1] = 7'h00;
        phase_poly[2] = CRC_POLY_RESET;      phase_dev[2] = DEVICE_ADDR_RESET;
        phase_poly[3] = 8'h31;               phase_dev[3] = 7'($urandom_range(0, 127));
        phase_poly[4] = 8'($urandom_range(0, 255));
        phase_dev[4]  = 7'($urandom_range(0, 127));
        phase_poly[5] = 8'h80;               phase_dev[5] = 7'h55;

        in_bus.valid   <= 1'b0;
        in_bus.payload <= '0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_CRC_POLY;
        cfg_data       <= 8'h00;
        i_rst_n        <= 1'b0;
        cur_poly = CRC_POLY_RESET;
        cur_dev  = DEVICE_ADDR_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_config(phase_poly[p], phase_dev[p]);
            run_random_phase();
        end
        wait_drained();

        if (errors == 0) begin
            $display("tb_crc8_framed_register_transfer_unit: done, clean");
        end else begin
            $display("tb_crc8_framed_register_transfer_unit: done, errors");
        end
        $finish;
    end

    // output side: changing stall patterns, plus one long hold-off to back up the block
    initial begin
        t_ready_mode mode;
        int          mode_left;
        int          tick;
        int          beats;
        bit          held_off;
        mode      = RDY_OPEN;
        mode_left = 0;
        tick      = 0;
        beats     = 0;
        held_off  = 1'b0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid && out_bus.ready) begin
                beats++;
            end
            tick++;
            if (!held_off && beats >= 150) begin
                held_off = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_ready_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    RDY_OPEN:    out_bus.ready <= 1'b1;
                    RDY_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
                    RDY_PATTERN: out_bus.ready <= ((tick % 5) != 0);
                    default:     out_bus.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

endmodule
